[rtl/tdhc_pkg.sv]
// Shared types and constants for the tap debounce and hold channel block.
package tdhc_pkg;

   localparam int CFG_WIDTH = 16;
   localparam int NUM_CHAN  = 3;

   // configuration register indexes
   localparam logic [1:0] REG_DEBOUNCE    = 2'd0;
   localparam logic [1:0] REG_LEFT_HOLD   = 2'd1;
   localparam logic [1:0] REG_RIGHT_HOLD  = 2'd2;
   localparam logic [1:0] REG_HAZARD_HOLD = 2'd3;

   // channel codes
   localparam logic [1:0] CH_LEFT   = 2'd0;
   localparam logic [1:0] CH_RIGHT  = 2'd1;
   localparam logic [1:0] CH_HAZARD = 2'd2;

   // operation codes
   localparam logic OP_TICK = 1'b0;
   localparam logic OP_EDGE = 1'b1;

   localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RESET = 16'd100;
   localparam logic [CFG_WIDTH-1:0] HOLD_RESET     = 16'd3000;

   typedef struct packed {
      logic [CFG_WIDTH-1:0]               debounce_ticks;
      logic [NUM_CHAN-1:0][CFG_WIDTH-1:0] hold_ticks;
   } cfg_type;

   typedef struct packed {
      logic tick;
      logic load_debounce;
      logic drive_off;
      logic level;
   } chan_cmd_type;

   typedef struct packed {
      logic drive;
      logic armed;
   } chan_stat_type;

endpackage

[rtl/tap_debounce_hold_channels_top.sv]
// Top level of the three-channel tap debounce and hold timer.
//
// Usage:
//   req channel: one transaction per event. req_tuser is the operation
//   (0 timer tick, 1 pin edge); req_tdata carries the edge channel and the
//   current pin levels. Every request yields exactly one rsp transaction
//   holding the drive bits and armed flags after that event.
//   csr channel: register writes (0 debounce ticks, 1..3 hold times for
//   left, right, hazard). csr_ready is always high; write only while idle.
// Pipeline: a request accepted into the input stage is processed when it
//   steps into the response stage, which happens once that stage is free;
//   rsp_tvalid is the registered valid flag of the response stage.
// Throughput: one transaction per cycle while rsp_tready is high; the channel update is a single
//   decrement and compare per counter between the input and output regs.
// Reset: synchronous, active high. Counters, flags and drives clear, the
//   registers return to 100 and 3000 ticks, both transaction stages empty.
// Stall: when rsp_tready is low the response holds; one more request is
//   taken into the input stage, then req_tready drops until rsp drains.
module tap_debounce_hold_channels_top
   import tdhc_pkg::*;
#(
   parameter int COUNT_WIDTH = 16
)
(
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,   // [1:0] channel, [4:2] input_levels, [7:5] zero
   input  logic                 req_tuser,   // [0] operation
   // response channel
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [7:0]           rsp_tdata,   // [2:0] output_states, [5:3] armed_flags, [7:6] zero
   // configuration write channel
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [1:0]           csr_index,
   input  logic [CFG_WIDTH-1:0] csr_data
);

   cfg_type cfg;

   logic                in_valid_ff, in_valid_in;
   logic                in_op_ff;
   logic [1:0]          in_ch_ff;
   logic [NUM_CHAN-1:0] in_lvl_ff;
   logic                out_valid_ff, out_valid_in;
   logic [NUM_CHAN-1:0] out_drive_ff;
   logic [NUM_CHAN-1:0] out_armed_ff;
   logic                req_fire;
   logic                step;

   chan_stat_type [NUM_CHAN-1:0] stat_next;

   assign csr_ready = 1'b1;

   tdhc_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid && csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   // advance the held request into the response stage when that stage frees up
   assign step        = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready  = !in_valid_ff || step;
   assign req_fire    = req_tvalid && req_tready;
   assign in_valid_in = req_fire ? 1'b1 : (step ? 1'b0 : in_valid_ff);
   assign out_valid_in = step ? 1'b1 : ((rsp_tready) ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // input stage payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_op_ff  <= req_tuser;
         in_ch_ff  <= req_tdata[1:0];
         in_lvl_ff <= req_tdata[4:2];
      end
   end

   // per-channel state; an edge on left drops right's drive and vice versa
   for (genvar c = 0; c < NUM_CHAN; c++) begin : g_chan
      chan_cmd_type cmd;

      assign cmd.tick          = (in_op_ff == OP_TICK);
      assign cmd.load_debounce = (in_op_ff == OP_EDGE) && (in_ch_ff == 2'(c));
      assign cmd.drive_off     = (in_op_ff == OP_EDGE) &&
                                 ((2'(c) == CH_RIGHT && in_ch_ff == CH_LEFT) ||
                                  (2'(c) == CH_LEFT  && in_ch_ff == CH_RIGHT));
      assign cmd.level         = in_lvl_ff[c];

      tdhc_chan #(
         .COUNT_WIDTH (COUNT_WIDTH)
      ) u_chan (
         .clock         (clock),
         .reset         (reset),
         .step          (step),
         .cmd           (cmd),
         .debounce_load (COUNT_WIDTH'(cfg.debounce_ticks)),
         .hold_load     (COUNT_WIDTH'(cfg.hold_ticks[c])),
         .stat_next     (stat_next[c])
      );

      // capture the post-update state as the response payload
      always_ff @(posedge clock) begin
         if (step) begin
            out_drive_ff[c] <= stat_next[c].drive;
            out_armed_ff[c] <= stat_next[c].armed;
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00, out_armed_ff, out_drive_ff};

endmodule

[rtl/tdhc_csr.sv]
// Configuration register file: debounce setting and per-channel hold times.
module tdhc_csr
   import tdhc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 wr_en,
   input  logic [1:0]           wr_index,
   input  logic [CFG_WIDTH-1:0] wr_data,
   output cfg_type              cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (wr_index)
            REG_DEBOUNCE:    cfg_in.debounce_ticks = wr_data;
            REG_LEFT_HOLD:   cfg_in.hold_ticks[0]  = wr_data;
            REG_RIGHT_HOLD:  cfg_in.hold_ticks[1]  = wr_data;
            REG_HAZARD_HOLD: cfg_in.hold_ticks[2]  = wr_data;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ticks <= DEBOUNCE_RESET;
         cfg_ff.hold_ticks     <= {NUM_CHAN{HOLD_RESET}};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[rtl/tdhc_chan.sv]
// One channel: debounce counter, hold counter, armed flag and drive bit.
module tdhc_chan
   import tdhc_pkg::*;
#(
   parameter int COUNT_WIDTH = 16
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  chan_cmd_type           cmd,
   input  logic [COUNT_WIDTH-1:0] debounce_load,
   input  logic [COUNT_WIDTH-1:0] hold_load,
   output chan_stat_type          stat_next
);

   logic [COUNT_WIDTH-1:0] deb_ff, deb_in, deb_dec;
   logic [COUNT_WIDTH-1:0] hold_ff, hold_in;
   logic                   armed_ff, armed_in;
   logic                   drive_ff, drive_in;

   always_comb begin
      deb_in   = deb_ff;
      hold_in  = hold_ff;
      armed_in = armed_ff;
      drive_in = drive_ff;
      deb_dec  = deb_ff - COUNT_WIDTH'(1);
      if (cmd.tick) begin
         if (armed_ff) begin
            if (hold_ff != '0) begin
               hold_in = hold_ff - COUNT_WIDTH'(1);
            end else begin
               // hold expired: disarm and clear
               hold_in  = '0;
               deb_in   = '0;
               armed_in = 1'b0;
               drive_in = 1'b0;
            end
         end else if (deb_ff != '0) begin
            deb_in = deb_dec;
            if (deb_dec == '0 && !cmd.level) begin
               hold_in  = hold_load;
               deb_in   = '0;
               armed_in = 1'b1;
               drive_in = 1'b1;
            end
         end
      end else begin
         if (cmd.load_debounce) begin
            deb_in = debounce_load;
         end
         if (cmd.drive_off) begin
            drive_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         deb_ff   <= '0;
         hold_ff  <= '0;
         armed_ff <= 1'b0;
         drive_ff <= 1'b0;
      end else if (step) begin
         deb_ff   <= deb_in;
         hold_ff  <= hold_in;
         armed_ff <= armed_in;
         drive_ff <= drive_in;
      end
   end

   assign stat_next.drive = drive_in;
   assign stat_next.armed = armed_in;

endmodule

[rtl/tdhc_checker.sv]
// Port-level checks for the tap debounce and hold block, bound to the top level.
module tdhc_checker
   import tdhc_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata
);

   // hold the response payload while the receiver stalls
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("response payload changed while stalled");

   // drop request ready only when the response stage is blocked
   a_ready_only_on_stall: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("request side stalled without a blocked response");

   // a channel drives only while it is armed
   a_drive_needs_armed: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[2:0] & ~rsp_tdata[5:3]) == 3'b000)
      else $error("drive bit set on a disarmed channel");

   // reset empties the response stage
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

endmodule

bind tap_debounce_hold_channels_top tdhc_checker u_tdhc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
